[src/iale_pkg.sv]
// shared types and codes for the indexed array list engine
package iale_pkg;

	localparam int DATA_W = 32;

	typedef logic signed [DATA_W-1:0] word_t;

	// command codes
	localparam logic [2:0] CMD_READ    = 3'd0;
	localparam logic [2:0] CMD_WRITE   = 3'd1;
	localparam logic [2:0] CMD_INSERT  = 3'd2;
	localparam logic [2:0] CMD_DELETE  = 3'd3;
	localparam logic [2:0] CMD_SEARCH  = 3'd4;
	localparam logic [2:0] CMD_REVERSE = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

endpackage

[src/indexed_array_list_engine.sv]
// top level of the indexed array list engine: sequencer around one list ram
//
//  channel   direction  handshake            payload
//  in        to block   in_valid / in_stall  command, position, data_value
//  out       from block out_valid/out_stall  read_data, found, found_position,
//                                            entry_count, status
//
// one command at a time; in_stall is high from acceptance until the result
// has been moved into the output register
// after decode, a write, an append at the end, a delete of the last entry and
// every failed command go straight to done; a read first captures the ram data,
// other inserts and deletes move entries one by one, a search compares from the
// front up to the first match and a reverse swaps pairs from both ends; the
// single ram write port and its registered read port set these steps
// the output register lets a new command start while a result waits; a second
// finished result waits in the done state as long as out_stall holds
// arst_n clears the count, the sequencer and the output valid; ram contents
// are undefined until written and only data read from live entries is ever used
module indexed_array_list_engine #(
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// command channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [2:0]                       command,
	input  logic [$clog2(DEPTH)-1:0]         position,
	input  logic signed [31:0]               data_value,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [31:0]               read_data,
	output logic                             found,
	output logic [$clog2(DEPTH)-1:0]         found_position,
	output logic [$clog2(DEPTH+1)-1:0]       entry_count,
	output logic [1:0]                       status
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_RDCAP    = 4'd2;
	localparam logic [3:0] S_SHIFT    = 4'd3;
	localparam logic [3:0] S_INS_LAST = 4'd4;
	localparam logic [3:0] S_SEARCH   = 4'd5;
	localparam logic [3:0] S_REV_RHI  = 4'd6;
	localparam logic [3:0] S_REV_WLO  = 4'd7;
	localparam logic [3:0] S_REV_WHI  = 4'd8;
	localparam logic [3:0] S_DONE     = 4'd9;

	logic [3:0]        state_q;
	logic [2:0]        cmd_q;
	logic [AW-1:0]     pos_q;
	iale_pkg::word_t   val_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     idx_q;     // walking index, also low end of reverse
	logic [AW-1:0]     hi_q;      // high end of reverse
	iale_pkg::word_t   tmp_q;     // low entry held during a swap

	// result being built
	iale_pkg::word_t   res_rd_q;
	logic              res_found_q;
	logic [AW-1:0]     res_fpos_q;
	logic [1:0]        res_st_q;

	// output register
	logic              out_valid_q;
	iale_pkg::word_t   read_data_q;
	logic              found_q;
	logic [AW-1:0]     found_position_q;
	logic [CW-1:0]     entry_count_q;
	logic [1:0]        status_q;

	// ram port
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	iale_pkg::word_t   ram_wdata;
	logic [AW-1:0]     ram_raddr;
	iale_pkg::word_t   ram_rdata;

	// checks on the latched command
	logic              pos_below_cnt;
	logic              pos_at_cnt;
	logic              list_full;
	logic              list_empty;
	logic              out_free;

	assign pos_below_cnt = CW'(pos_q) < cnt_q;
	assign pos_at_cnt    = CW'(pos_q) == cnt_q;
	assign list_full     = cnt_q == CW'(DEPTH);
	assign list_empty    = cnt_q == '0;
	assign out_free      = !out_valid_q || !out_stall;

	assign in_stall = state_q != S_IDLE;

	iale_ram #(
		.WIDTH (iale_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ram control; reads that end up unused are harmless
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		ram_raddr = idx_q;
		case (state_q)
			S_DECODE: begin
				case (cmd_q)
					iale_pkg::CMD_READ: begin
						ram_raddr = pos_q;
					end
					iale_pkg::CMD_WRITE: begin
						ram_we    = pos_below_cnt;
						ram_waddr = pos_q;
						ram_wdata = val_q;
					end
					iale_pkg::CMD_INSERT: begin
						// append at the end needs no shift
						ram_we    = !list_full && pos_at_cnt;
						ram_waddr = pos_q;
						ram_wdata = val_q;
						ram_raddr = AW'(cnt_q - CW'(1));
					end
					iale_pkg::CMD_DELETE: begin
						ram_raddr = pos_q + AW'(1);
					end
					iale_pkg::CMD_SEARCH: begin
						ram_raddr = '0;
					end
					iale_pkg::CMD_REVERSE: begin
						ram_raddr = '0;
					end
					default: begin
						ram_raddr = idx_q;
					end
				endcase
			end
			S_SHIFT: begin
				// move the entry read last cycle one place over
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
				if (cmd_q == iale_pkg::CMD_INSERT) begin
					ram_raddr = idx_q - AW'(2);
				end else begin
					ram_raddr = idx_q + AW'(2);
				end
			end
			S_INS_LAST: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = val_q;
			end
			S_SEARCH: begin
				ram_raddr = idx_q + AW'(1);
			end
			S_REV_RHI: begin
				ram_raddr = hi_q;
			end
			S_REV_WLO: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
			end
			S_REV_WHI: begin
				// finish the swap and fetch the next low entry
				ram_we    = 1'b1;
				ram_waddr = hi_q;
				ram_wdata = tmp_q;
				ram_raddr = idx_q + AW'(1);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q <= S_DONE;
					case (cmd_q)
						iale_pkg::CMD_READ: begin
							if (pos_below_cnt) begin
								state_q <= S_RDCAP;
							end
						end
						iale_pkg::CMD_INSERT: begin
							if (!list_full && pos_at_cnt) begin
								cnt_q <= cnt_q + CW'(1);
							end else if (!list_full && pos_below_cnt) begin
								state_q <= S_SHIFT;
							end
						end
						iale_pkg::CMD_DELETE: begin
							if (!list_empty && pos_below_cnt) begin
								if (CW'(pos_q) + CW'(1) == cnt_q) begin
									cnt_q <= cnt_q - CW'(1);
								end else begin
									state_q <= S_SHIFT;
								end
							end
						end
						iale_pkg::CMD_SEARCH: begin
							if (!list_empty) begin
								state_q <= S_SEARCH;
							end
						end
						iale_pkg::CMD_REVERSE: begin
							if (cnt_q > CW'(1)) begin
								state_q <= S_REV_RHI;
							end
						end
						default: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_RDCAP: begin
					state_q <= S_DONE;
				end
				S_SHIFT: begin
					if (cmd_q == iale_pkg::CMD_INSERT) begin
						if (idx_q - AW'(1) == pos_q) begin
							state_q <= S_INS_LAST;
						end
					end else if ((CW+1)'(idx_q) + (CW+1)'(2) >= (CW+1)'(cnt_q)) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_INS_LAST: begin
					cnt_q   <= cnt_q + CW'(1);
					state_q <= S_DONE;
				end
				S_SEARCH: begin
					if (ram_rdata == val_q ||
					    (CW+1)'(idx_q) + (CW+1)'(1) >= (CW+1)'(cnt_q)) begin
						state_q <= S_DONE;
					end
				end
				S_REV_RHI: begin
					state_q <= S_REV_WLO;
				end
				S_REV_WLO: begin
					state_q <= S_REV_WHI;
				end
				S_REV_WHI: begin
					if ((AW+1)'(idx_q) + (AW+1)'(2) < (AW+1)'(hi_q)) begin
						state_q <= S_REV_RHI;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= command;
				pos_q <= position;
				val_q <= data_value;
			end
			S_DECODE: begin
				res_rd_q    <= '0;
				res_found_q <= 1'b0;
				res_fpos_q  <= '0;
				res_st_q    <= iale_pkg::ST_OK;
				idx_q       <= '0;
				hi_q        <= AW'(cnt_q - CW'(1));
				case (cmd_q)
					iale_pkg::CMD_READ: begin
						if (!pos_below_cnt) begin
							res_st_q <= iale_pkg::ST_RANGE;
						end
					end
					iale_pkg::CMD_WRITE: begin
						if (!pos_below_cnt) begin
							res_st_q <= iale_pkg::ST_RANGE;
						end
					end
					iale_pkg::CMD_INSERT: begin
						idx_q <= AW'(cnt_q);
						if (list_full) begin
							res_st_q <= iale_pkg::ST_FULL;
						end else if (!pos_below_cnt && !pos_at_cnt) begin
							res_st_q <= iale_pkg::ST_RANGE;
						end
					end
					iale_pkg::CMD_DELETE: begin
						idx_q <= pos_q;
						if (list_empty) begin
							res_st_q <= iale_pkg::ST_EMPTY;
						end else if (!pos_below_cnt) begin
							res_st_q <= iale_pkg::ST_RANGE;
						end
					end
					default: begin
						res_st_q <= iale_pkg::ST_OK;
					end
				endcase
			end
			S_RDCAP: begin
				res_rd_q <= ram_rdata;
			end
			S_SHIFT: begin
				if (cmd_q == iale_pkg::CMD_INSERT) begin
					idx_q <= idx_q - AW'(1);
				end else begin
					idx_q <= idx_q + AW'(1);
				end
			end
			S_SEARCH: begin
				if (ram_rdata == val_q) begin
					res_found_q <= 1'b1;
					res_fpos_q  <= idx_q;
				end else begin
					idx_q <= idx_q + AW'(1);
				end
			end
			S_REV_RHI: begin
				tmp_q <= ram_rdata;
			end
			S_REV_WHI: begin
				idx_q <= idx_q + AW'(1);
				hi_q  <= hi_q - AW'(1);
			end
			default: begin
				tmp_q <= tmp_q;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			read_data_q      <= res_rd_q;
			found_q          <= res_found_q;
			found_position_q <= res_fpos_q;
			entry_count_q    <= cnt_q;
			status_q         <= res_st_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign read_data      = read_data_q;
	assign found          = found_q;
	assign found_position = found_position_q;
	assign entry_count    = entry_count_q;
	assign status         = status_q;

`ifndef SYNTHESIS
	// the count never passes the list size
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	// one command moves the count by one at most
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |->
			(cnt_q == $past(cnt_q) + CW'(1)) || (cnt_q == $past(cnt_q) - CW'(1)))
		else $error("entry count jumped");

	// shifting writes stay within the live list plus the new slot
	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> CW'(ram_waddr) <= cnt_q)
		else $error("shift write beyond live entries");

	// a new result only follows the end of a command
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result shown without a finished command");

	// a hit always carries ok status
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> status_q == iale_pkg::ST_OK)
		else $error("found with error status");
`endif

endmodule

[src/iale_ram.sv]
// generic simple dual port ram, one write and one registered read port
module iale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[tb/sv/list_checker.sv]
// result checker for the indexed array list engine: tracks the list and compares every result
`timescale 1ns / 100ps

module list_checker #(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [2:0]                 command,
	input  logic [$clog2(DEPTH)-1:0]   position,
	input  logic signed [31:0]         data_value,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic signed [31:0]         read_data,
	input  logic                       found,
	input  logic [$clog2(DEPTH)-1:0]   found_position,
	input  logic [$clog2(DEPTH+1)-1:0] entry_count,
	input  logic [1:0]                 status,
	output int                         error_count,
	output int                         pending,
	output logic [$clog2(DEPTH+1)-1:0] list_size
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef struct packed {
		iale_pkg::word_t             read_data;
		logic                        found;
		logic [$clog2(DEPTH)-1:0]    found_position;
		logic [$clog2(DEPTH+1)-1:0]  entry_count;
		logic [1:0]                  status;
	} list_result_t;

	iale_pkg::word_t list_entries [DEPTH];
	int              live_entries;
	int              mismatches;
	list_result_t    awaited_results [$];

	assign error_count = mismatches;

	initial begin
		mismatches = 0;
		foreach (list_entries[i])
			list_entries[i] = '0;
	end

	// applies one command to the tracked list and returns the result it should give
	task automatic run_command(input logic [2:0] cmd, input int pos,
			input iale_pkg::word_t value, output list_result_t res);
		int              i;
		int              lo;
		int              hi;
		iale_pkg::word_t swap_word;
		res = '0;
		case (cmd)
			iale_pkg::CMD_READ: begin
				if (pos < live_entries)
					res.read_data = list_entries[pos];
				else
					res.status = iale_pkg::ST_RANGE;
			end
			iale_pkg::CMD_WRITE: begin
				if (pos < live_entries)
					list_entries[pos] = value;
				else
					res.status = iale_pkg::ST_RANGE;
			end
			iale_pkg::CMD_INSERT: begin
				if (live_entries >= DEPTH) begin
					res.status = iale_pkg::ST_FULL;
				end else if (pos > live_entries) begin
					res.status = iale_pkg::ST_RANGE;
				end else begin
					for (i = live_entries; i > pos; i--)
						list_entries[i] = list_entries[i-1];
					list_entries[pos] = value;
					live_entries++;
				end
			end
			iale_pkg::CMD_DELETE: begin
				if (live_entries == 0) begin
					res.status = iale_pkg::ST_EMPTY;
				end else if (pos >= live_entries) begin
					res.status = iale_pkg::ST_RANGE;
				end else begin
					for (i = pos; i + 1 < live_entries; i++)
						list_entries[i] = list_entries[i+1];
					live_entries--;
				end
			end
			iale_pkg::CMD_SEARCH: begin
				for (i = 0; i < live_entries && !res.found; i++) begin
					if (list_entries[i] == value) begin
						res.found = 1'b1;
						res.found_position = AW'(i);
					end
				end
			end
			iale_pkg::CMD_REVERSE: begin
				lo = 0;
				hi = live_entries - 1;
				while (lo < hi) begin
					swap_word = list_entries[lo];
					list_entries[lo] = list_entries[hi];
					list_entries[hi] = swap_word;
					lo++;
					hi--;
				end
			end
			default: ;
		endcase
		res.entry_count = CW'(live_entries);
	endtask

	task automatic check_field(input string field, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		list_result_t predicted;
		if (!arst_n) begin
			live_entries = 0;
			awaited_results.delete();
			pending <= 0;
			list_size <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, read_data %0d status %0d", $time,
						read_data, status);
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					check_field("read_data", 64'(want.read_data), 64'(read_data));
					check_field("found", 64'(want.found), 64'(found));
					check_field("found_position", 64'(want.found_position),
						64'(found_position));
					check_field("entry_count", 64'(want.entry_count), 64'(entry_count));
					check_field("status", 64'(want.status), 64'(status));
				end
			end
			if (in_valid && !in_stall) begin
				run_command(command, int'(position), data_value, predicted);
				awaited_results.push_back(predicted);
			end
			pending <= awaited_results.size();
			list_size <= CW'(live_entries);
		end
	end

endmodule

[tb/sv/testbench.sv]
// top of the indexed array list engine testbench: stimulus, result-side stalls and verdict
`timescale 1ns / 100ps

module testbench;

	localparam int DEPTH = 16;
	// codes the block has no command for; it must answer them without touching the list
	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;
	localparam int RANDOM_ITEMS = 1225;
	// generous bound on cycles with no handshake at all, well above the long hold-off
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_START = 320;
	localparam int HOLD_CYCLES = 250;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [2:0]                 command;
	logic [3:0]                 position;
	logic signed [31:0]         data_value;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [31:0]         read_data;
	logic                       found;
	logic [3:0]                 found_position;
	logic [4:0]                 entry_count;
	logic [1:0]                 status;

	int                         error_count;
	int                         pending;
	logic [4:0]                 list_size;
	// sender gaps are switched off for one stretch of the random part
	logic                       quiet_sender;
	int                         idle_cycles;

	indexed_array_list_engine #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.position(position),
		.data_value(data_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.found(found),
		.found_position(found_position),
		.entry_count(entry_count),
		.status(status)
	);

	list_checker #(
		.DEPTH(DEPTH)
	) checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.position(position),
		.data_value(data_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.found(found),
		.found_position(found_position),
		.entry_count(entry_count),
		.status(status),
		.error_count(error_count),
		.pending(pending),
		.list_size(list_size)
	);

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: ends the run when no item moves on either channel for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random stalls, one long hold-off while the sender keeps going,
	// and a stretch with no stalls at all
	initial begin
		int cycles;
		cycles = 0;
		out_stall <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (cycles == HOLD_START) begin
				// long hold-off so the output register and then the engine fill up
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				cycles += HOLD_CYCLES;
			end else begin
				if (cycles >= 2500 && cycles < 5500)
					out_stall <= 1'b0;
				else
					out_stall <= ($urandom_range(0, 99) < 14);
				@(posedge clk);
				cycles++;
			end
		end
	end

	// offers one item, with random gaps ahead of it, and returns at the edge that takes it;
	// valid stays up so the next item can follow without a gap
	task automatic send_item(input logic [2:0] cmd, input logic [3:0] pos,
			input iale_pkg::word_t value);
		while (!quiet_sender && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		position <= pos;
		data_value <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	initial begin
		logic            growing;
		logic [2:0]      cmd;
		logic [3:0]      pos;
		iale_pkg::word_t value;
		int              roll;
		int              pick;
		int              reach;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= iale_pkg::CMD_READ;
		position <= '0;
		data_value <= '0;
		quiet_sender = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: read, delete, search and reverse on an empty list
		send_item(iale_pkg::CMD_READ, 4'd0, 32'sd0);
		send_item(iale_pkg::CMD_DELETE, 4'd0, 32'sd0);
		send_item(iale_pkg::CMD_SEARCH, 4'd0, 32'sd0);
		send_item(iale_pkg::CMD_REVERSE, 4'd0, 32'sd0);
		// insert past the end of an empty list
		send_item(iale_pkg::CMD_INSERT, 4'd15, 32'sd5);
		// value extremes at the front, back and middle
		send_item(iale_pkg::CMD_INSERT, 4'd0, 32'sh8000_0000);
		send_item(iale_pkg::CMD_INSERT, 4'd1, 32'sh7fff_ffff);
		send_item(iale_pkg::CMD_INSERT, 4'd0, -32'sd1);
		send_item(iale_pkg::CMD_INSERT, 4'd1, 32'sh7fff_ffff);
		send_item(iale_pkg::CMD_INSERT, 4'd5, 32'sd1);
		// duplicate key: the first match must win
		send_item(iale_pkg::CMD_SEARCH, 4'd0, 32'sh7fff_ffff);
		send_item(iale_pkg::CMD_READ, 4'd3, 32'sd0);
		send_item(iale_pkg::CMD_READ, 4'd4, 32'sd0);
		send_item(iale_pkg::CMD_WRITE, 4'd4, 32'sd1);
		send_item(iale_pkg::CMD_WRITE, 4'd2, 32'sd0);
		send_item(iale_pkg::CMD_REVERSE, 4'd0, 32'sd0);
		send_item(iale_pkg::CMD_SEARCH, 4'd0, 32'sd123);
		send_item(CMD_SPARE_A, 4'd7, -32'sd1);
		send_item(CMD_SPARE_B, 4'd15, 32'sh7fff_ffff);
		send_item(iale_pkg::CMD_DELETE, 4'd4, 32'sd0);
		send_item(iale_pkg::CMD_DELETE, 4'd0, 32'sd0);
		send_item(iale_pkg::CMD_DELETE, 4'd2, 32'sd0);
		send_item(iale_pkg::CMD_INSERT, 4'd2, 32'sd9);
		send_item(iale_pkg::CMD_REVERSE, 4'd0, 32'sd0);
		send_item(iale_pkg::CMD_READ, 4'd15, 32'sd0);

		// random part: the list is grown to full and drained to empty over and over,
		// lingering at both ends so full inserts and empty deletes come up often
		growing = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 600) begin
				// sender pause until every result is back
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			quiet_sender = (n >= 300 && n < 560);

			if (growing && list_size == DEPTH && $urandom_range(0, 3) == 0)
				growing = 1'b0;
			else if (!growing && list_size == 0 && $urandom_range(0, 3) == 0)
				growing = 1'b1;

			roll = $urandom_range(0, 99);
			if (roll < 40)
				cmd = growing ? iale_pkg::CMD_INSERT : iale_pkg::CMD_DELETE;
			else if (roll < 50)
				cmd = growing ? iale_pkg::CMD_DELETE : iale_pkg::CMD_INSERT;
			else if (roll < 63)
				cmd = iale_pkg::CMD_READ;
			else if (roll < 75)
				cmd = iale_pkg::CMD_WRITE;
			else if (roll < 88)
				cmd = iale_pkg::CMD_SEARCH;
			else if (roll < 95)
				cmd = iale_pkg::CMD_REVERSE;
			else if (roll < 97)
				cmd = CMD_SPARE_A;
			else
				cmd = CMD_SPARE_B;

			// mostly near the live range, sometimes anywhere
			reach = (list_size > 15) ? 15 : list_size;
			if ($urandom_range(0, 4) == 0)
				pos = 4'($urandom_range(0, 15));
			else
				pos = 4'($urandom_range(0, reach));

			// a small pool of values keeps searches hitting and duplicates around
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				value = $urandom_range(0, 7);
			end else if (pick == 4) begin
				case ($urandom_range(0, 3))
					0: value = 32'sh8000_0000;
					1: value = 32'sh7fff_ffff;
					2: value = -32'sd1;
					default: value = 32'sd0;
				endcase
			end else begin
				value = $urandom;
			end

			send_item(cmd, pos, value);
		end
		in_valid <= 1'b0;

		// drain, then allow for the slowest command to show any stray result
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (error_count == 0 && pending == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
